// ----- sv/rcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfr_pkg
// Shared types, constants and the CRC-8 step for the RC channel frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package rcfr_pkg;

	localparam int unsigned STORE_DEPTH = 64;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	localparam int unsigned POS_W       = 7;
	localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 7'd64;

	localparam int unsigned CHAN_W      = 11;
	localparam int unsigned CHAN_IDX_W  = 4;
	localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL = 4'd15;

	// bit accumulator: up to ten leftover bits plus one byte
	localparam int unsigned ACC_W       = CHAN_W - 1 + 8;
	localparam int unsigned CNT_W       = $clog2(ACC_W + 1);

	localparam logic [7:0] RC_TYPE      = 8'h16;
	localparam logic [7:0] RC_LENGTH    = 8'd24;
	localparam logic [7:0] CRC_POLY     = 8'hD5;
	localparam logic [STORE_AW-1:0] FIRST_PAYLOAD = 6'd3;

	// whole channel frame: address, length, type, payload and crc
	localparam logic [POS_W-1:0] RC_FRAME_BYTES = 7'd26;

	localparam logic [3:0]  GAP_MAX     = 4'hF;
	localparam logic [10:0] FS_MAX      = 11'h7FF;

	// input kind codes
	localparam logic KIND_BYTE          = 1'b0;
	localparam logic KIND_TICK          = 1'b1;

	// result kind codes
	localparam logic RES_CHANNEL        = 1'b0;
	localparam logic RES_STATUS         = 1'b1;

	// configuration register indexes
	localparam logic REG_GAP_LIMIT      = 1'b0;
	localparam logic REG_FS_LIMIT       = 1'b1;

	typedef struct packed {
		logic                  valid;
		logic [CHAN_IDX_W-1:0] index;
		logic [CHAN_W-1:0]     value;
		logic                  last;
	} chan_item_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/rcfr_ram.sv -----
// ----------------------------------------------------------------------------
// rcfr_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- sv/rcfr_unpack.sv -----
// ----------------------------------------------------------------------------
// rcfr_unpack
// Sequencer that streams payload bytes through a bit accumulator and cuts
// sixteen 11-bit channels from it, one store read or one channel per step
// ----------------------------------------------------------------------------
`default_nettype none

module rcfr_unpack
	import rcfr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                out_free,
	input  wire logic [7:0]          rd_data,
	output      logic [STORE_AW-1:0] rd_addr,
	output      logic                busy,
	output      chan_item_t          chan
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [STORE_AW-1:0]   addr_q;
	logic [ACC_W-1:0]      acc_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CHAN_IDX_W-1:0] ch_q;

	logic [CNT_W-1:0]      cnt_add;
	logic [CNT_W-1:0]      cnt_sub;

	assign cnt_add = cnt_q + CNT_W'(8);
	assign cnt_sub = cnt_q - CNT_W'(CHAN_W);

	assign rd_addr     = addr_q;
	assign busy        = (state_q != ST_IDLE);
	assign chan.valid  = (state_q == ST_EMIT) && out_free;
	assign chan.index  = ch_q;
	assign chan.value  = acc_q[CHAN_W-1:0];
	assign chan.last   = (ch_q == LAST_CHANNEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						addr_q  <= FIRST_PAYLOAD;
						acc_q   <= '0;
						cnt_q   <= '0;
						ch_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// read of addr_q in flight
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					acc_q  <= acc_q | (ACC_W'(rd_data) << cnt_q);
					cnt_q  <= cnt_add;
					addr_q <= addr_q + STORE_AW'(1);
					if (cnt_add >= CNT_W'(CHAN_W)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						acc_q <= acc_q >> CHAN_W;
						cnt_q <= cnt_sub;
						ch_q  <= ch_q + CHAN_IDX_W'(1);
						if (ch_q == LAST_CHANNEL) begin
							state_q <= ST_IDLE;
						end else if (cnt_sub >= CNT_W'(CHAN_W)) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == ST_IDLE))
		else $error("frame start while unpacking");

	a_emit_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (cnt_q >= CNT_W'(CHAN_W)))
		else $error("channel cut from too few bits");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(chan.valid && chan.last) |=> (state_q == ST_IDLE))
		else $error("sequencer still busy after last channel");

	a_shift_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ($past(state_q) == ST_LOAD))
		else $error("store data taken without a read");

endmodule

`default_nettype wire

// ----- sv/rc_channel_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// rc_channel_frame_receiver_core
// Link byte frame assembly, CRC check, gap and failsafe timers, channel output
// ----------------------------------------------------------------------------
// Input items on s_axis carry either a received link byte (tuser = 0) or a
// timer tick (tuser = 1). Bytes are stored into a 64-entry frame store and the
// CRC-8 is folded in as they arrive. A tick gives one status item on m_axis
// carrying the failsafe flag.
// When a byte completes a valid channel frame the unpack sequencer reads the
// 22 payload bytes from the store, each read passing through a load and a
// shift state, and cuts out the sixteen channel items through one shared bit
// accumulator; while it runs, s_axis_tready is low.
// One output register parts the two sides; a new item is taken while the
// held item is being taken. When m_axis_tready is low the result holds and
// s_axis_tready drops until the output register frees.
// Reset clears the frame position, timers and limits (gap 1, failsafe 32);
// the store needs no clearing. Configuration writes go through cfg_we,
// cfg_addr and cfg_data; the user must write only while idle (no check here).
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_frame_receiver_core
	import rcfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_addr,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // data_byte
	input  wire logic        s_axis_tuser,   // kind
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata,   // channel_index, channel_value, failsafe_active
	output      logic        m_axis_tuser,   // result_kind
	output      logic        m_axis_tlast    // last_of_frame
);

	logic [3:0]          gap_limit_q;
	logic [9:0]          fs_limit_q;
	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    exp_q;
	logic [3:0]          gap_q;
	logic [10:0]         fs_q;
	logic [7:0]          type_q;
	logic [7:0]          crc_q;
	logic                m_valid_q;
	logic [15:0]         m_data_q;
	logic                m_user_q;
	logic                m_last_q;

	logic                out_free;
	logic                in_acc;
	logic                byte_acc;
	logic                tick_acc;
	logic                store_en;
	logic [POS_W-1:0]    pos_inc;
	logic [8:0]          total;
	logic [POS_W-1:0]    len_exp;
	logic [POS_W-1:0]    exp_n;
	logic                done;
	logic                frame_ok;
	logic [3:0]          gap_inc;
	logic [10:0]         fs_inc;
	logic                gap_expire;
	logic                fs_flag;
	logic                busy;
	logic [STORE_AW-1:0] rd_addr;
	logic [7:0]          rd_data;
	chan_item_t          chan;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !busy && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign byte_acc      = in_acc && (s_axis_tuser == KIND_BYTE);
	assign tick_acc      = in_acc && (s_axis_tuser == KIND_TICK);

	assign store_en = byte_acc && (pos_q < exp_q);
	assign pos_inc  = pos_q + POS_W'(1);
	assign total    = 9'(s_axis_tdata) + 9'd2;
	assign len_exp  = (total >= 9'(MAX_FRAME_BYTES)) ? '0 : total[POS_W-1:0];
	assign exp_n    = (pos_inc == POS_W'(2)) ? len_exp : exp_q;
	assign done     = store_en && (pos_inc == exp_n);
	// a frame of length 24 is the only one that completes with this total
	assign frame_ok = done && (type_q == RC_TYPE) && (exp_q == RC_FRAME_BYTES) &&
		(crc_q == s_axis_tdata);

	assign gap_inc    = (gap_q == GAP_MAX) ? gap_q : gap_q + 4'd1;
	assign fs_inc     = (fs_q == FS_MAX) ? fs_q : fs_q + 11'd1;
	assign gap_expire = (gap_inc > gap_limit_q);
	assign fs_flag    = (fs_inc > {1'b0, fs_limit_q});

	rcfr_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_en),
		.waddr (pos_q[STORE_AW-1:0]),
		.wdata (s_axis_tdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	rcfr_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (frame_ok),
		.out_free (out_free),
		.rd_data  (rd_data),
		.rd_addr  (rd_addr),
		.busy     (busy),
		.chan     (chan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= 4'd1;
			fs_limit_q  <= 10'd32;
			pos_q       <= '0;
			exp_q       <= MAX_FRAME_BYTES;
			gap_q       <= '0;
			fs_q        <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_GAP_LIMIT: gap_limit_q <= cfg_data[3:0];
					REG_FS_LIMIT:  fs_limit_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (byte_acc) begin
				gap_q <= '0;
				if (store_en) begin
					if (done) begin
						pos_q <= '0;
						exp_q <= MAX_FRAME_BYTES;
					end else begin
						pos_q <= pos_inc;
						exp_q <= exp_n;
					end
				end
				if (frame_ok) begin
					fs_q <= '0;
				end
			end
			if (tick_acc) begin
				gap_q <= gap_inc;
				fs_q  <= fs_inc;
				if (gap_expire) begin
					pos_q <= '0;
					exp_q <= MAX_FRAME_BYTES;
				end
			end
			if (tick_acc || chan.valid) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// frame header, running crc and output payload
	always_ff @(posedge clk) begin
		if (store_en) begin
			if (pos_q == POS_W'(2)) begin
				type_q <= s_axis_tdata;
			end
			if (pos_q >= POS_W'(2)) begin
				crc_q <= crc8_step((pos_q == POS_W'(2)) ? 8'd0 : crc_q, s_axis_tdata);
			end
		end
		if (tick_acc) begin
			m_user_q <= RES_STATUS;
			m_data_q <= {fs_flag, CHAN_W'(0), CHAN_IDX_W'(0)};
			m_last_q <= 1'b0;
		end else if (chan.valid) begin
			m_user_q <= RES_CHANNEL;
			m_data_q <= {1'b0, chan.value, chan.index};
			m_last_q <= chan.last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// ----- test/rc_channel_frame_receiver_core_tb.sv -----
// ----------------------------------------------------------------------------
// rc_channel_frame_receiver_core_tb
// Self-checking bench for the RC channel frame receiver core
// ----------------------------------------------------------------------------
// Link bytes and timer ticks go in on s_axis with random gaps while m_axis
// stalls at random. A bench-side frame decoder keeps its own frame store,
// gap and failsafe timers and limits, and queues the channel and status items
// each accepted input should give; every output item is checked field by
// field against the oldest queued one. A short table of directed rows (reset
// values, all-zero and all-one payloads, broken frames, implausible and zero
// lengths, limit extremes, gap saturation) comes first, then random phases of
// mostly well-formed frames with random content under several limit settings.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_frame_receiver_core_tb;
	import rcfr_pkg::*;

	localparam int LIMIT_CYCLES   = 1000000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int RAND_PER_PHASE = 30;
	localparam int FRAME_BYTES    = 26;

	typedef struct packed {
		logic                  kind;
		logic [CHAN_IDX_W-1:0] idx;
		logic [CHAN_W-1:0]     val;
		logic                  last;
		logic                  fs;
	} rc_out_t;

	typedef enum logic [1:0] {ROW_TICK, ROW_BYTE, ROW_FRAME, ROW_CFG} row_op_e;
	typedef enum logic [2:0] {FRM_GOOD, FRM_BAD_CRC, FRM_BAD_TYPE, FRM_BAD_LEN,
		FRM_GAPPED} frame_mode_e;

	typedef struct packed {
		row_op_e       op;
		frame_mode_e   mode;
		logic [7:0]    data;
		logic [9:0]    lim;
		logic          typed;
		logic [10:0]   exp_val;
		logic          exp_fs;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_addr = '0;
	logic [9:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // data_byte
	logic        s_axis_tuser = 1'b0; // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // channel_index, channel_value, failsafe_active
	logic        m_axis_tuser;        // result_kind
	logic        m_axis_tlast;        // last_of_frame

	rc_channel_frame_receiver_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// decoder state
	logic [7:0]  fr_store [STORE_DEPTH];
	logic [6:0]  fr_pos = '0;
	logic [6:0]  fr_expect = MAX_FRAME_BYTES;
	logic [3:0]  gap_cnt = '0;
	logic [10:0] fs_cnt = '0;
	logic [3:0]  gap_lim = 4'd1;
	logic [9:0]  fs_lim = 10'd32;

	rc_out_t     expected_rc_items [$];
	rc_out_t     decoded_now [$];
	logic [7:0]  frame_buf [FRAME_BYTES];
	bit          no_idle = 1'b0;
	int          items_sent = 0;
	int          fail_count = 0;
	int          stall_left = 0;

	dir_row_t plan [26] = '{
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_FRAME, FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_FRAME, FRM_GOOD,     8'hFF, 10'd0,    1'b1, 11'd2047, 1'b0},
		'{ROW_FRAME, FRM_GOOD,     8'h5A, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_FRAME, FRM_BAD_CRC,  8'hA5, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_FRAME, FRM_BAD_TYPE, 8'h00, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_FRAME, FRM_BAD_LEN,  8'h33, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'hC8, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'h00, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'hC8, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'h3E, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'hFF, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'hC8, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_BYTE,  FRM_GOOD,     8'hFF, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b0},
		'{ROW_CFG,   FRM_GOOD,     8'h00, 10'd0,    1'b0, 11'd0,    1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b1},
		'{ROW_FRAME, FRM_GOOD,     8'hFF, 10'd0,    1'b1, 11'd2047, 1'b0},
		'{ROW_TICK,  FRM_GOOD,     8'h00, 10'd0,    1'b1, 11'd0,    1'b1},
		'{ROW_CFG,   FRM_GOOD,     8'h0F, 10'd1023, 1'b0, 11'd0,    1'b0},
		'{ROW_FRAME, FRM_GAPPED,   8'hC3, 10'd0,    1'b0, 11'd0,    1'b0}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic void unpack_frame();
		logic [7:0]  crc;
		logic [23:0] w;
		logic [23:0] sh;
		rc_out_t     o;
		int          bitpos;
		int          base;
		crc = 8'h00;
		for (int i = 2; i < 2 + RC_LENGTH - 1; i++)
			crc = crc8_fold(crc, fr_store[i]);
		if (fr_store[2] == RC_TYPE && fr_store[1] == RC_LENGTH && crc == fr_store[25]) begin
			fs_cnt = '0;
			for (int ch = 0; ch < 16; ch++) begin
				bitpos = ch * 11;
				base = 3 + bitpos / 8;
				w = {fr_store[base + 2], fr_store[base + 1], fr_store[base]};
				sh = w >> (bitpos % 8);
				o.kind = RES_CHANNEL;
				o.idx = ch[3:0];
				o.val = sh[10:0];
				o.last = (ch[3:0] == LAST_CHANNEL);
				o.fs = (fs_cnt > fs_lim);
				decoded_now.push_back(o);
			end
		end
		fr_pos = '0;
		fr_expect = MAX_FRAME_BYTES;
	endfunction

	function automatic void decode_link_item(input logic kind, input logic [7:0] b);
		logic [8:0] total;
		rc_out_t    o;
		decoded_now.delete();
		if (kind == KIND_BYTE) begin
			gap_cnt = '0;
			if (fr_pos < fr_expect) begin
				fr_store[fr_pos[5:0]] = b;
				fr_pos = fr_pos + 7'd1;
				if (fr_pos == 7'd2) begin
					total = 9'd2 + fr_store[1];
					fr_expect = (total >= MAX_FRAME_BYTES) ? 7'd0 : total[6:0];
				end
				if (fr_pos == fr_expect)
					unpack_frame();
			end
		end else begin
			if (gap_cnt != GAP_MAX)
				gap_cnt = gap_cnt + 4'd1;
			if (gap_cnt > gap_lim) begin
				fr_pos = '0;
				fr_expect = MAX_FRAME_BYTES;
			end
			if (fs_cnt != FS_MAX)
				fs_cnt = fs_cnt + 11'd1;
			o = '0;
			o.kind = RES_STATUS;
			o.fs = (fs_cnt > fs_lim);
			decoded_now.push_back(o);
		end
	endfunction

	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void seal_frame(input logic [7:0] ftype);
		logic [7:0] crc;
		frame_buf[1] = RC_LENGTH;
		frame_buf[2] = ftype;
		crc = 8'h00;
		for (int i = 2; i < FRAME_BYTES - 1; i++)
			crc = crc8_fold(crc, frame_buf[i]);
		frame_buf[FRAME_BYTES - 1] = crc;
	endfunction

	task automatic send_item(input logic kind, input logic [7:0] b, input bit typed,
		input logic [10:0] exp_val, input logic exp_fs);
		int      g;
		rc_out_t o;
		g = idle_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		decode_link_item(kind, b);
		if (!typed) begin
			foreach (decoded_now[i])
				expected_rc_items.push_back(decoded_now[i]);
		end else if (kind == KIND_TICK) begin
			o = '0;
			o.kind = RES_STATUS;
			o.fs = exp_fs;
			expected_rc_items.push_back(o);
		end else begin
			for (int ch = 0; ch < 16; ch++) begin
				o.kind = RES_CHANNEL;
				o.idx = ch[3:0];
				o.val = exp_val;
				o.last = (ch == 15);
				o.fs = 1'b0;
				expected_rc_items.push_back(o);
			end
		end
	endtask

	task automatic send_frame(input bit typed, input logic [10:0] exp_val, input int hold_at,
		input int hold_ticks, input int tick_odds);
		for (int i = 0; i < FRAME_BYTES; i++) begin
			send_item(KIND_BYTE, frame_buf[i], typed && i == FRAME_BYTES - 1, exp_val, 1'b0);
			if (i == hold_at)
				repeat (hold_ticks) send_item(KIND_TICK, 8'($urandom), 1'b0, 11'd0, 1'b0);
			if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
				repeat ($urandom_range(1, 3))
					send_item(KIND_TICK, 8'($urandom), 1'b0, 11'd0, 1'b0);
		end
	endtask

	// only while idle: all items out and the unpack pass long over
	task automatic write_limits(input logic [3:0] g, input logic [9:0] f);
		s_axis_tvalid <= 1'b0;
		while (expected_rc_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_GAP_LIMIT;
		cfg_data <= {6'($urandom), g};
		@(posedge clk);
		cfg_addr <= REG_FS_LIMIT;
		cfg_data <= f;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_lim = g;
		fs_lim = f;
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : rx_ready
		int g;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			g = idle_gap();
			if (g == 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				stall_left <= g - 1;
			end
		end
	end

	always @(posedge clk) begin : rx_check
		rc_out_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_rc_items.size() == 0) begin
				$error("unexpected output item: tuser %0b tdata %h tlast %0b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				e = expected_rc_items.pop_front();
				check_field("result_kind", e.kind, m_axis_tuser);
				check_field("channel_index", e.idx, m_axis_tdata[3:0]);
				check_field("channel_value", e.val, m_axis_tdata[14:4]);
				check_field("last_of_frame", e.last, m_axis_tlast);
				check_field("failsafe_active", e.fs, m_axis_tdata[15]);
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int         base;
		int         r;
		int         len;
		logic [3:0] g;
		logic [9:0] f;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].op)
				ROW_TICK: begin
					send_item(KIND_TICK, 8'($urandom), plan[i].typed, 11'd0,
						plan[i].exp_fs);
				end
				ROW_BYTE: begin
					send_item(KIND_BYTE, plan[i].data, 1'b0, 11'd0, 1'b0);
				end
				ROW_CFG: begin
					write_limits(plan[i].data[3:0], plan[i].lim);
				end
				default: begin
					frame_buf[0] = 8'hC8;
					for (int p = 3; p < FRAME_BYTES - 1; p++)
						frame_buf[p] = plan[i].data;
					seal_frame(plan[i].mode == FRM_BAD_TYPE ? RC_TYPE + 8'd1 : RC_TYPE);
					if (plan[i].mode == FRM_BAD_CRC)
						frame_buf[FRAME_BYTES - 1] = ~frame_buf[FRAME_BYTES - 1];
					if (plan[i].mode == FRM_BAD_LEN)
						frame_buf[1] = RC_LENGTH - 8'd1;
					send_frame(plan[i].typed, plan[i].exp_val,
						plan[i].mode == FRM_GAPPED ? 5 : -1, 20, 0);
				end
			endcase
		end

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin g = 4'd1;  f = 10'd32;   end
				1: begin g = 4'd0;  f = 10'd0;    end
				2: begin g = 4'd15; f = 10'd1023; end
				3: begin g = 4'd15; f = 10'd0;    end
				4: begin g = 4'd0;  f = 10'd1023; end
				default: begin
					g = 4'($urandom_range(0, 15));
					f = 10'($urandom_range(0, 60));
				end
			endcase
			write_limits(g, f);
			no_idle = ($urandom_range(0, 3) == 0);
			base = items_sent;
			while (items_sent < base + RAND_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					// well-formed frame, sometimes with one flipped bit
					frame_buf[0] = 8'($urandom);
					for (int p = 3; p < FRAME_BYTES - 1; p++)
						frame_buf[p] = ($urandom_range(0, 5) == 0) ?
							{8{1'($urandom)}} : 8'($urandom);
					seal_frame(RC_TYPE);
					if ($urandom_range(0, 3) == 0)
						frame_buf[$urandom_range(1, FRAME_BYTES - 1)] ^=
							8'(1 << $urandom_range(0, 7));
					send_frame(1'b0, 11'd0, -1, 0, $urandom_range(0, 1) ? 0 : 12);
				end else if (r < 70) begin
					repeat ($urandom_range(1, 20))
						send_item(KIND_TICK, 8'($urandom), 1'b0, 11'd0, 1'b0);
				end else if (r < 85) begin
					case ($urandom_range(0, 3))
						0: len = RC_LENGTH;
						1: len = $urandom_range(61, 62);
						default: len = $urandom_range(0, 8);
					endcase
					send_item(KIND_BYTE, 8'($urandom), 1'b0, 11'd0, 1'b0);
					send_item(KIND_BYTE, len[7:0], 1'b0, 11'd0, 1'b0);
					repeat ($urandom_range(0, len + 1))
						send_item(KIND_BYTE, 8'($urandom), 1'b0, 11'd0, 1'b0);
				end else begin
					repeat ($urandom_range(1, 6))
						send_item(1'($urandom), 8'($urandom), 1'b0, 11'd0, 1'b0);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (expected_rc_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
sv/rcfr_pkg.sv
sv/rcfr_ram.sv
sv/rcfr_unpack.sv
sv/rc_channel_frame_receiver_core.sv
test/rc_channel_frame_receiver_core_tb.sv
